[hw/rtl/ebalu_pkg.sv]
// ebalu_pkg: shared types for the eight-bit alu with flags
// command codes and the flag register layout
// no dependencies
package ebalu_pkg;

  localparam int unsigned CmdWidth  = 5;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned BitIdxW   = 3;

  // operation codes carried by the command field
  typedef enum logic [CmdWidth-1:0] {
    CMD_ADD    = 5'd0,
    CMD_ADC    = 5'd1,
    CMD_SUB    = 5'd2,
    CMD_SBC    = 5'd3,
    CMD_AND    = 5'd4,
    CMD_XOR    = 5'd5,
    CMD_OR     = 5'd6,
    CMD_CP     = 5'd7,
    CMD_INC    = 5'd8,
    CMD_DEC    = 5'd9,
    CMD_RLC    = 5'd10,
    CMD_RRC    = 5'd11,
    CMD_RL     = 5'd12,
    CMD_RR     = 5'd13,
    CMD_SLA    = 5'd14,
    CMD_SRA    = 5'd15,
    CMD_SWAP   = 5'd16,
    CMD_SRL    = 5'd17,
    CMD_BIT    = 5'd18,
    CMD_RES    = 5'd19,
    CMD_SET    = 5'd20,
    CMD_RLCA   = 5'd21,
    CMD_RRCA   = 5'd22,
    CMD_RLA    = 5'd23,
    CMD_RRA    = 5'd24,
    CMD_DAA    = 5'd25,
    CMD_CPL    = 5'd26,
    CMD_SCF    = 5'd27,
    CMD_CCF    = 5'd28,
    CMD_LD_A   = 5'd29,
    CMD_LD_F   = 5'd30
  } cmd_e;

  // flag register, z in bit 3 down to c in bit 0
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

endpackage

[hw/rtl/eight_bit_alu_with_flags_core.sv]
// eight_bit_alu_with_flags_core: top level of the eight-bit alu with flags
// input register, ebalu_exec datapath, accumulator/flag state and result register
// depends on ebalu_pkg and ebalu_exec
//
// usage
//   input channel: in_valid_i/in_ready_o carry one beat of command, operand and
//   bit index. output channel: out_valid_o/out_ready_i carry one beat of the
//   written-back byte, the accumulator and the four flags.
//   every input beat gives exactly one output beat, in order.
//   the result beat passes through the input register and then the result
//   register; a stall on the output side holds it in the input register.
//   throughput: one beat per cycle while the output side is not stalled; the
//   accumulator and flags are read and rewritten combinationally in the execute
//   step between the input register and the result register.
//   the accumulator and flags update when a beat moves from the input register
//   into the result register, so later beats always see earlier results.
//   reset clears both registers' valid bits, the accumulator and the flags.
//   when the receiver stalls, the result register holds its beat, the input
//   register fills, and in_ready_o then drops until the result is taken.
module eight_bit_alu_with_flags_core
  import ebalu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CmdWidth-1:0]  command_i,
  input  logic [ByteWidth-1:0] operand_i,
  input  logic [BitIdxW-1:0]   bit_index_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ByteWidth-1:0] value_o,
  output logic [ByteWidth-1:0] accumulator_o,
  output logic                 zero_flag_o,
  output logic                 subtract_flag_o,
  output logic                 half_carry_flag_o,
  output logic                 carry_flag_o
);

  logic                 in_vld_q;
  cmd_e                 cmd_q;
  logic [ByteWidth-1:0] operand_q;
  logic [BitIdxW-1:0]   bit_index_q;

  logic [ByteWidth-1:0] acc_q, acc_d;
  flags_t               flags_q, flags_d;
  logic [ByteWidth-1:0] value_d;

  logic                 out_vld_q;
  logic [ByteWidth-1:0] value_q;
  logic [ByteWidth-1:0] out_acc_q;
  flags_t               out_flags_q;

  logic                 exec_go;
  logic                 in_fire;

  // stage handshake
  assign exec_go    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || exec_go;
  assign in_fire    = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q       <= cmd_e'(command_i);
      operand_q   <= operand_i;
      bit_index_q <= bit_index_i;
    end
  end

  // execute
  ebalu_exec u_exec (
    .command_i   (cmd_q),
    .operand_i   (operand_q),
    .bit_index_i (bit_index_q),
    .acc_i       (acc_q),
    .flags_i     (flags_q),
    .value_o     (value_d),
    .acc_o       (acc_d),
    .flags_o     (flags_d)
  );

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      flags_q <= '0;
    end else if (exec_go) begin
      acc_q   <= acc_d;
      flags_q <= flags_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (exec_go) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      value_q     <= value_d;
      out_acc_q   <= acc_d;
      out_flags_q <= flags_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign value_o           = value_q;
  assign accumulator_o     = out_acc_q;
  assign zero_flag_o       = out_flags_q.z;
  assign subtract_flag_o   = out_flags_q.n;
  assign half_carry_flag_o = out_flags_q.h;
  assign carry_flag_o      = out_flags_q.c;

endmodule

[hw/rtl/ebalu_exec.sv]
// ebalu_exec: combinational datapath of one alu operation
// computes the written-back byte, next accumulator and next flags
// depends on ebalu_pkg
module ebalu_exec
  import ebalu_pkg::*;
(
  input  cmd_e                 command_i,
  input  logic [ByteWidth-1:0] operand_i,
  input  logic [BitIdxW-1:0]   bit_index_i,
  input  logic [ByteWidth-1:0] acc_i,
  input  flags_t               flags_i,
  output logic [ByteWidth-1:0] value_o,
  output logic [ByteWidth-1:0] acc_o,
  output flags_t               flags_o
);

  // rotate and shift kinds, same order for the cb group and the accumulator group
  typedef enum logic [2:0] {
    SH_RLC  = 3'd0,
    SH_RRC  = 3'd1,
    SH_RL   = 3'd2,
    SH_RR   = 3'd3,
    SH_SLA  = 3'd4,
    SH_SRA  = 3'd5,
    SH_SWAP = 3'd6,
    SH_SRL  = 3'd7
  } shift_e;

  // returns {carry out, result byte}
  function automatic logic [ByteWidth:0] shift_byte(input shift_e kind,
                                                    input logic [ByteWidth-1:0] x,
                                                    input logic cin);
    logic [ByteWidth:0] res;
    case (kind)
      SH_RLC:  res = {x[7], x[6:0], x[7]};
      SH_RRC:  res = {x[0], x[0], x[7:1]};
      SH_RL:   res = {x[7], x[6:0], cin};
      SH_RR:   res = {x[0], cin, x[7:1]};
      SH_SLA:  res = {x[7], x[6:0], 1'b0};
      SH_SRA:  res = {x[0], x[7], x[7:1]};
      SH_SWAP: res = {1'b0, x[3:0], x[7:4]};
      SH_SRL:  res = {x[0], 1'b0, x[7:1]};
      default: res = {1'b0, x};
    endcase
    return res;
  endfunction

  logic [ByteWidth-1:0] a, b;
  logic                 cin;
  logic                 ci_add, ci_sub;
  logic [ByteWidth:0]   sum9, diff9;
  logic [4:0]           hsum, hdiff;
  logic [ByteWidth-1:0] inc_r, dec_r;
  shift_e               kind_cb, kind_acc;
  logic [ByteWidth:0]   sh_cb, sh_acc;
  logic [ByteWidth-1:0] bit_mask;
  logic [ByteWidth-1:0] daa_r;
  logic                 daa_c;

  assign a   = acc_i;
  assign b   = operand_i;
  assign cin = flags_i.c;

  // adder and subtractor, carry-in only for the with-carry forms
  assign ci_add = (command_i == CMD_ADC) ? cin : 1'b0;
  assign ci_sub = (command_i == CMD_SBC) ? cin : 1'b0;
  assign sum9   = {1'b0, a} + {1'b0, b} + {{ByteWidth{1'b0}}, ci_add};
  assign hsum   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, ci_add};
  assign diff9  = {1'b0, a} - {1'b0, b} - {{ByteWidth{1'b0}}, ci_sub};
  assign hdiff  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, ci_sub};

  assign inc_r = b + 8'd1;
  assign dec_r = b - 8'd1;

  // rotate unit for the operand and for the accumulator
  assign kind_cb  = shift_e'(3'(command_i - CMD_RLC));
  assign kind_acc = shift_e'(3'(command_i - CMD_RLCA));
  assign sh_cb    = shift_byte(kind_cb, b, cin);
  assign sh_acc   = shift_byte(kind_acc, a, cin);

  assign bit_mask = 8'(1) << bit_index_i;

  // decimal adjust, corrections picked from the unadjusted accumulator
  always_comb begin
    daa_r = a;
    daa_c = flags_i.c;
    if (!flags_i.n) begin
      if (flags_i.c || (a > 8'h99)) begin
        daa_r = daa_r + 8'h60;
        daa_c = 1'b1;
      end
      if (flags_i.h || (a[3:0] > 4'h9)) begin
        daa_r = daa_r + 8'h06;
      end
    end else begin
      if (flags_i.c) begin
        daa_r = daa_r - 8'h60;
      end
      if (flags_i.h) begin
        daa_r = daa_r - 8'h06;
      end
    end
  end

  // operation select
  always_comb begin
    value_o = a;
    acc_o   = a;
    flags_o = flags_i;
    case (command_i)
      CMD_ADD, CMD_ADC: begin
        acc_o   = sum9[7:0];
        value_o = sum9[7:0];
        flags_o = '{z: (sum9[7:0] == 8'h00), n: 1'b0, h: hsum[4], c: sum9[8]};
      end
      CMD_SUB, CMD_SBC: begin
        acc_o   = diff9[7:0];
        value_o = diff9[7:0];
        flags_o = '{z: (diff9[7:0] == 8'h00), n: 1'b1, h: hdiff[4], c: diff9[8]};
      end
      CMD_CP: begin
        flags_o = '{z: (diff9[7:0] == 8'h00), n: 1'b1, h: hdiff[4], c: diff9[8]};
      end
      CMD_AND: begin
        acc_o   = a & b;
        value_o = a & b;
        flags_o = '{z: ((a & b) == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      CMD_XOR: begin
        acc_o   = a ^ b;
        value_o = a ^ b;
        flags_o = '{z: ((a ^ b) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      CMD_OR: begin
        acc_o   = a | b;
        value_o = a | b;
        flags_o = '{z: ((a | b) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      CMD_INC: begin
        value_o = inc_r;
        flags_o = '{z: (inc_r == 8'h00), n: 1'b0, h: (b[3:0] == 4'hF), c: flags_i.c};
      end
      CMD_DEC: begin
        value_o = dec_r;
        flags_o = '{z: (dec_r == 8'h00), n: 1'b1, h: (b[3:0] == 4'h0), c: flags_i.c};
      end
      CMD_RLC, CMD_RRC, CMD_RL, CMD_RR, CMD_SLA, CMD_SRA, CMD_SWAP, CMD_SRL: begin
        value_o = sh_cb[7:0];
        flags_o = '{z: (sh_cb[7:0] == 8'h00), n: 1'b0, h: 1'b0, c: sh_cb[8]};
      end
      CMD_RLCA, CMD_RRCA, CMD_RLA, CMD_RRA: begin
        acc_o   = sh_acc[7:0];
        value_o = sh_acc[7:0];
        flags_o = '{z: 1'b0, n: 1'b0, h: 1'b0, c: sh_acc[8]};
      end
      CMD_BIT: begin
        value_o = b;
        flags_o = '{z: ((b & bit_mask) == 8'h00), n: 1'b0, h: 1'b1, c: flags_i.c};
      end
      CMD_RES: begin
        value_o = b & ~bit_mask;
      end
      CMD_SET: begin
        value_o = b | bit_mask;
      end
      CMD_DAA: begin
        acc_o   = daa_r;
        value_o = daa_r;
        flags_o = '{z: (daa_r == 8'h00), n: flags_i.n, h: 1'b0, c: daa_c};
      end
      CMD_CPL: begin
        acc_o   = ~a;
        value_o = ~a;
        flags_o = '{z: flags_i.z, n: 1'b1, h: 1'b1, c: flags_i.c};
      end
      CMD_SCF: begin
        flags_o = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      CMD_CCF: begin
        flags_o = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: ~flags_i.c};
      end
      CMD_LD_A: begin
        acc_o   = b;
        value_o = b;
      end
      CMD_LD_F: begin
        flags_o = flags_t'(b[7:4]);
      end
      default: begin
        value_o = a;
      end
    endcase
  end

endmodule

[hw/rtl/ebalu_checker.sv]
// ebalu_checker: port-level assertions for the eight-bit alu with flags
// bound to eight_bit_alu_with_flags_core
// depends on ebalu_pkg
module ebalu_checker
  import ebalu_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [CmdWidth-1:0]  command_i,
  input logic [ByteWidth-1:0] operand_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [ByteWidth-1:0] value_o,
  input logic [ByteWidth-1:0] accumulator_o,
  input logic                 zero_flag_o,
  input logic                 subtract_flag_o,
  input logic                 half_carry_flag_o,
  input logic                 carry_flag_o
);

  // after a reset edge nothing is held and input is open
  assert property (@(posedge clk_i) !rst_ni |=> (!out_valid_o && in_ready_o))
    else $error("ebalu: pipeline not empty during reset");

  // input back-pressure only when the result beat is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("ebalu: input blocked without output stall");

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && !out_ready_i) |=>
                   (out_valid_o && $stable(value_o) && $stable(accumulator_o)))
    else $error("ebalu: stalled result changed");

  // load a shows up after the input and result registers with a free output side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_valid_i && in_ready_o && (command_i == CMD_LD_A) && out_ready_i)
                   ##1 out_ready_i |=>
                   (out_valid_o && (accumulator_o == $past(operand_i, 2))
                    && (value_o == $past(operand_i, 2))))
    else $error("ebalu: load a result wrong");

  // load flags shows up after the input and result registers with a free output side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_valid_i && in_ready_o && (command_i == CMD_LD_F) && out_ready_i)
                   ##1 out_ready_i |=>
                   (out_valid_o && (zero_flag_o == $past(operand_i[7], 2))
                    && (subtract_flag_o == $past(operand_i[6], 2))
                    && (half_carry_flag_o == $past(operand_i[5], 2))
                    && (carry_flag_o == $past(operand_i[4], 2))))
    else $error("ebalu: load flags result wrong");

endmodule

bind eight_bit_alu_with_flags_core ebalu_checker u_ebalu_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .command_i         (command_i),
  .operand_i         (operand_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .value_o           (value_o),
  .accumulator_o     (accumulator_o),
  .zero_flag_o       (zero_flag_o),
  .subtract_flag_o   (subtract_flag_o),
  .half_carry_flag_o (half_carry_flag_o),
  .carry_flag_o      (carry_flag_o)
);
